// ===== design/midi_style_command_byte_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the command byte parser.
// ---------------------------------------------------------------------------
`ifndef MIDI_STYLE_COMMAND_BYTE_PARSER_DEFINES_SVH
`define MIDI_STYLE_COMMAND_BYTE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every clk edge outside reset
`define MSCBP_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("mscbp: same-cycle check failed");
// next-cycle implication
`define MSCBP_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("mscbp: next-cycle check failed");
`else
`define MSCBP_ASSERT_IMP(lbl, ant, con)
`define MSCBP_ASSERT_NXT(lbl, ant, con)
`endif

`endif

// ===== design/mscbp_pkg.sv =====
// ---------------------------------------------------------------------------
// mscbp_pkg
// Shared constants, event codes and controller/datapath bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package mscbp_pkg;

  localparam int SYSEX_DEPTH_DEF = 32;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 4;
  localparam int PORT_W = 7;
  localparam int VAL_W  = 14;

  // received command bytes
  localparam logic [7:0] CMD_DIGITAL        = 8'h90;
  localparam logic [7:0] CMD_REPORT_ANALOG  = 8'hC0;
  localparam logic [7:0] CMD_REPORT_DIGITAL = 8'hD0;
  localparam logic [7:0] CMD_ANALOG         = 8'hE0;
  localparam logic [7:0] CMD_SYSEX_START    = 8'hF0;
  localparam logic [7:0] CMD_PIN_MODE       = 8'hF4;
  localparam logic [7:0] CMD_SYSEX_END      = 8'hF7;
  localparam logic [7:0] CMD_VERSION        = 8'hF9;
  localparam logic [7:0] CMD_RESET          = 8'hFF;

  // sysex body commands
  localparam logic [7:0] SX_STRING   = 8'h71;
  localparam logic [7:0] SX_FIRMWARE = 8'h79;

  // event kinds
  localparam logic [KIND_W-1:0] EV_ANALOG         = 4'd0;
  localparam logic [KIND_W-1:0] EV_DIGITAL        = 4'd1;
  localparam logic [KIND_W-1:0] EV_PIN_MODE       = 4'd2;
  localparam logic [KIND_W-1:0] EV_REPORT_ANALOG  = 4'd3;
  localparam logic [KIND_W-1:0] EV_REPORT_DIGITAL = 4'd4;
  localparam logic [KIND_W-1:0] EV_RESET          = 4'd5;
  localparam logic [KIND_W-1:0] EV_VERSION        = 4'd6;
  localparam logic [KIND_W-1:0] EV_FIRMWARE       = 4'd7;
  localparam logic [KIND_W-1:0] EV_STRING_HDR     = 4'd8;
  localparam logic [KIND_W-1:0] EV_STRING_CHAR    = 4'd9;
  localparam logic [KIND_W-1:0] EV_SYSEX_HDR      = 4'd10;
  localparam logic [KIND_W-1:0] EV_SYSEX_BYTE     = 4'd11;

  // short message waiting for its data bytes
  localparam logic [2:0] PEND_NONE     = 3'd0;
  localparam logic [2:0] PEND_ANALOG   = 3'd1;
  localparam logic [2:0] PEND_DIGITAL  = 3'd2;
  localparam logic [2:0] PEND_PIN_MODE = 3'd3;
  localparam logic [2:0] PEND_REP_AN   = 3'd4;
  localparam logic [2:0] PEND_REP_DIG  = 3'd5;

  typedef struct packed {
    logic process;   // decode held byte, update parser state
    logic ptr_inc;   // advance buffer read pointer
    logic lo_cap;    // capture low byte of a string pair
    logic emit_pay;  // load one payload event into the output register
  } mscbp_cmd_t;

  typedef struct packed {
    logic in_full;      // a received byte is held
    logic needs_out;    // held byte produces an event
    logic start_drain;  // held byte ends a sysex with payload events to follow
    logic is_string;    // current drain joins byte pairs
    logic out_free;     // output register can take an event this cycle
    logic cnt_last;     // one payload event left
  } mscbp_sts_t;

endpackage

`default_nettype wire

// ===== design/mscbp_rx_if.sv =====
// ---------------------------------------------------------------------------
// mscbp_rx_if
// Received byte channel: valid/ready handshake with one byte payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface mscbp_rx_if;
  import mscbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/mscbp_ev_if.sv =====
// ---------------------------------------------------------------------------
// mscbp_ev_if
// Decoded event channel: valid/ready handshake with the event fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface mscbp_ev_if;
  import mscbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [PORT_W-1:0] port_or_pin;
  logic [VAL_W-1:0]  value;
  logic [BYTE_W-1:0] sysex_command;
  logic              overflow;
  logic              last;

  modport source (output valid, output event_kind, output port_or_pin, output value,
                  output sysex_command, output overflow, output last, input ready);
  modport sink   (input valid, input event_kind, input port_or_pin, input value,
                  input sysex_command, input overflow, input last, output ready);
endinterface

`default_nettype wire

// ===== design/mscbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// mscbp_ctrl
// Sequencer: decodes held bytes and steps the sysex payload drain.
// ---------------------------------------------------------------------------
`default_nettype none

module mscbp_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mscbp_pkg::mscbp_sts_t   sts,
  output mscbp_pkg::mscbp_cmd_t   cmd
);
  import mscbp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_LO   = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (sts.in_full && (!sts.needs_out || sts.out_free)) begin
          cmd.process = 1'b1;
          if (sts.start_drain) state_nxt = S_RD;
        end
      end
      S_RD: begin
        // buffer read data lands at the end of this cycle
        if (sts.is_string) begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_LO;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_LO: begin
        cmd.lo_cap = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_pay = 1'b1;
          state_nxt    = sts.cnt_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// ===== design/mscbp_datapath.sv =====
// ---------------------------------------------------------------------------
// mscbp_datapath
// Byte holding register, parser state, sysex body buffer and event register.
// ---------------------------------------------------------------------------
`default_nettype none

module mscbp_datapath #(
  parameter int SYSEX_DEPTH = mscbp_pkg::SYSEX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mscbp_rx_if.sink              in_ch,
  mscbp_ev_if.source            out_ch,
  input  mscbp_pkg::mscbp_cmd_t cmd,
  output mscbp_pkg::mscbp_sts_t sts
);
  import mscbp_pkg::*;

  localparam int AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
  localparam int LW = $clog2(SYSEX_DEPTH + 1);

  // input holding register
  logic [BYTE_W-1:0] byte_r;
  logic              full_r;

  // parser state
  logic [1:0]        aw_r, aw_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic [3:0]        chan_r, chan_nxt;
  logic [6:0]        sd0_r, sd0_nxt, sd1_r, sd1_nxt;
  logic              sx_r, sx_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic              drop_r, drop_nxt;
  logic [BYTE_W-1:0] scmd_r, scmd_nxt;

  // drain state
  logic [LW-1:0]     ptr_r;
  logic [LW-1:0]     cnt_r;
  logic              str_r;
  logic [BYTE_W-1:0] lo_r;
  logic [BYTE_W-1:0] rd_r;
  logic [BYTE_W-1:0] mem [SYSEX_DEPTH];

  // output register
  logic              ov_r;
  logic [KIND_W-1:0] o_kind_r;
  logic [PORT_W-1:0] o_port_r;
  logic [VAL_W-1:0]  o_val_r;
  logic [BYTE_W-1:0] o_cmd_r;
  logic              o_ovf_r;
  logic              o_last_r;

  // decode of the held byte
  logic              ev_hit;
  logic [KIND_W-1:0] ev_kind;
  logic [PORT_W-1:0] ev_port;
  logic [VAL_W-1:0]  ev_val;
  logic [BYTE_W-1:0] ev_cmd;
  logic              ev_ovf;
  logic              ev_last;
  logic              wr_en;
  logic              drain;
  logic              drain_str;
  logic [LW-1:0]     drain_cnt;
  logic [BYTE_W-1:0] cmd_byte;
  logic [LW-1:0]     len_m1;
  logic [LW-1:0]     pairs;

  assign len_m1 = len_r - LW'(1);
  assign pairs  = len_m1 >> 1;

  always_comb begin
    aw_nxt    = aw_r;
    pend_nxt  = pend_r;
    chan_nxt  = chan_r;
    sd0_nxt   = sd0_r;
    sd1_nxt   = sd1_r;
    sx_nxt    = sx_r;
    len_nxt   = len_r;
    drop_nxt  = drop_r;
    scmd_nxt  = scmd_r;
    ev_hit    = 1'b0;
    ev_kind   = EV_ANALOG;
    ev_port   = '0;
    ev_val    = '0;
    ev_cmd    = '0;
    ev_ovf    = 1'b0;
    ev_last   = 1'b0;
    wr_en     = 1'b0;
    drain     = 1'b0;
    drain_str = 1'b0;
    drain_cnt = '0;
    cmd_byte  = byte_r;

    if (sx_r) begin
      if (byte_r == CMD_SYSEX_END) begin
        sx_nxt = 1'b0;
        ev_hit = 1'b1;
        ev_ovf = drop_r;
        if (len_r == '0) begin
          ev_kind = EV_SYSEX_HDR;
          ev_last = 1'b1;
        end else if (scmd_r == SX_FIRMWARE) begin
          ev_kind = EV_FIRMWARE;
          ev_cmd  = scmd_r;
          ev_last = 1'b1;
        end else if (scmd_r == SX_STRING) begin
          ev_kind   = EV_STRING_HDR;
          ev_val    = {{(VAL_W-LW){1'b0}}, pairs};
          ev_cmd    = scmd_r;
          ev_last   = (pairs == '0);
          drain     = (pairs != '0);
          drain_str = 1'b1;
          drain_cnt = pairs;
        end else begin
          ev_kind   = EV_SYSEX_HDR;
          ev_val    = {{(VAL_W-LW){1'b0}}, len_m1};
          ev_cmd    = scmd_r;
          ev_last   = (len_m1 == '0);
          drain     = (len_m1 != '0);
          drain_cnt = len_m1;
        end
      end else if (len_r < LW'(SYSEX_DEPTH)) begin
        wr_en   = 1'b1;
        len_nxt = len_r + LW'(1);
        if (len_r == '0) scmd_nxt = byte_r;
      end else begin
        drop_nxt = 1'b1;
      end
    end else if (aw_r != 2'd0 && !byte_r[7]) begin
      aw_nxt = aw_r - 2'd1;
      // first of two data bytes lands in sd1, the final one in sd0
      if (aw_nxt[0]) sd1_nxt = byte_r[6:0];
      else           sd0_nxt = byte_r[6:0];
      if (aw_nxt == 2'd0 && pend_r != PEND_NONE) begin
        pend_nxt = PEND_NONE;
        ev_last  = 1'b1;
        unique case (pend_r)
          PEND_ANALOG: begin
            ev_hit  = 1'b1;
            ev_kind = EV_ANALOG;
            ev_port = {3'b000, chan_r};
            ev_val  = {byte_r[6:0], sd1_r};
          end
          PEND_DIGITAL: begin
            ev_hit  = 1'b1;
            ev_kind = EV_DIGITAL;
            ev_port = {3'b000, chan_r};
            ev_val  = {byte_r[6:0], sd1_r};
          end
          PEND_PIN_MODE: begin
            ev_hit  = 1'b1;
            ev_kind = EV_PIN_MODE;
            ev_port = sd1_r;
            ev_val  = {7'd0, byte_r[6:0]};
          end
          PEND_REP_AN: begin
            ev_hit  = 1'b1;
            ev_kind = EV_REPORT_ANALOG;
            ev_port = {3'b000, chan_r};
            ev_val  = {7'd0, byte_r[6:0]};
          end
          PEND_REP_DIG: begin
            ev_hit  = 1'b1;
            ev_kind = EV_REPORT_DIGITAL;
            ev_port = {3'b000, chan_r};
            ev_val  = {7'd0, byte_r[6:0]};
          end
          default: ev_hit = 1'b0;
        endcase
      end
    end else begin
      // channel commands carry the channel in the low nibble
      if (byte_r < CMD_SYSEX_START) begin
        cmd_byte = {byte_r[7:4], 4'h0};
        chan_nxt = byte_r[3:0];
      end
      unique case (cmd_byte)
        CMD_ANALOG: begin
          aw_nxt   = 2'd2;
          pend_nxt = PEND_ANALOG;
        end
        CMD_DIGITAL: begin
          aw_nxt   = 2'd2;
          pend_nxt = PEND_DIGITAL;
        end
        CMD_PIN_MODE: begin
          aw_nxt   = 2'd2;
          pend_nxt = PEND_PIN_MODE;
        end
        CMD_REPORT_ANALOG: begin
          aw_nxt   = 2'd1;
          pend_nxt = PEND_REP_AN;
        end
        CMD_REPORT_DIGITAL: begin
          aw_nxt   = 2'd1;
          pend_nxt = PEND_REP_DIG;
        end
        CMD_SYSEX_START: begin
          sx_nxt   = 1'b1;
          len_nxt  = '0;
          drop_nxt = 1'b0;
        end
        CMD_RESET: begin
          aw_nxt   = 2'd0;
          pend_nxt = PEND_NONE;
          chan_nxt = 4'd0;
          sd0_nxt  = 7'd0;
          sd1_nxt  = 7'd0;
          sx_nxt   = 1'b0;
          len_nxt  = '0;
          drop_nxt = 1'b0;
          ev_hit   = 1'b1;
          ev_kind  = EV_RESET;
          ev_last  = 1'b1;
        end
        CMD_VERSION: begin
          ev_hit  = 1'b1;
          ev_kind = EV_VERSION;
          ev_last = 1'b1;
        end
        default: ev_hit = 1'b0;
      endcase
    end
  end

  // holding register
  assign in_ch.ready = !full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ch.valid && !full_r) begin
      full_r <= 1'b1;
    end else if (cmd.process) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && !full_r) byte_r <= in_ch.rx_byte;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r   <= 2'd0;
      pend_r <= PEND_NONE;
      chan_r <= 4'd0;
      sd0_r  <= 7'd0;
      sd1_r  <= 7'd0;
      sx_r   <= 1'b0;
      len_r  <= '0;
      drop_r <= 1'b0;
      scmd_r <= '0;
    end else if (cmd.process) begin
      aw_r   <= aw_nxt;
      pend_r <= pend_nxt;
      chan_r <= chan_nxt;
      sd0_r  <= sd0_nxt;
      sd1_r  <= sd1_nxt;
      sx_r   <= sx_nxt;
      len_r  <= len_nxt;
      drop_r <= drop_nxt;
      scmd_r <= scmd_nxt;
    end
  end

  // body buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.process && wr_en) mem[len_r[AW-1:0]] <= byte_r;
    rd_r <= mem[ptr_r[AW-1:0]];
  end

  // drain pointer and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
      str_r <= 1'b0;
    end else begin
      if (cmd.process && drain) begin
        ptr_r <= LW'(1);
        cnt_r <= drain_cnt;
        str_r <= drain_str;
      end else begin
        if (cmd.ptr_inc || cmd.emit_pay) ptr_r <= ptr_r + LW'(1);
        if (cmd.emit_pay)                cnt_r <= cnt_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lo_cap) lo_r <= rd_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if ((cmd.process && ev_hit) || cmd.emit_pay) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.process && ev_hit) begin
      o_kind_r <= ev_kind;
      o_port_r <= ev_port;
      o_val_r  <= ev_val;
      o_cmd_r  <= ev_cmd;
      o_ovf_r  <= ev_ovf;
      o_last_r <= ev_last;
    end else if (cmd.emit_pay) begin
      o_kind_r <= str_r ? EV_STRING_CHAR : EV_SYSEX_BYTE;
      o_port_r <= '0;
      // low byte plus bit 0 of the high byte shifted to bit 7, modulo 256
      o_val_r  <= str_r ? {6'd0, lo_r[7] ^ rd_r[0], lo_r[6:0]} : {6'd0, rd_r};
      o_cmd_r  <= scmd_r;
      o_ovf_r  <= drop_r;
      o_last_r <= (cnt_r == LW'(1));
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.event_kind    = o_kind_r;
  assign out_ch.port_or_pin   = o_port_r;
  assign out_ch.value         = o_val_r;
  assign out_ch.sysex_command = o_cmd_r;
  assign out_ch.overflow      = o_ovf_r;
  assign out_ch.last          = o_last_r;

  assign sts.in_full     = full_r;
  assign sts.needs_out   = ev_hit;
  assign sts.start_drain = drain;
  assign sts.is_string   = str_r;
  assign sts.out_free    = !ov_r || out_ch.ready;
  assign sts.cnt_last    = (cnt_r == LW'(1));

endmodule

`default_nettype wire

// ===== design/midi_style_command_byte_parser.sv =====
// A transferred byte is held and decoded; its event is registered in the output register.
// Input takes a new byte only once the held byte is decoded.
// On sysex end the header leaves at decode; each body byte is then read and emitted, and each
// string character after its low and high bytes, paced by the buffer's single read port.
// Reset is synchronous, active low, and clears the parser; the body buffer is not cleared.
// ---------------------------------------------------------------------------
// midi_style_command_byte_parser
// Receive parser for a MIDI-style control protocol with sysex buffering.
// ---------------------------------------------------------------------------
`default_nettype none

`include "midi_style_command_byte_parser_defines.svh"

module midi_style_command_byte_parser #(
  parameter int SYSEX_DEPTH = mscbp_pkg::SYSEX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mscbp_rx_if.sink    in_ch,
  mscbp_ev_if.source  out_ch
);
  import mscbp_pkg::*;

  mscbp_cmd_t cmd;
  mscbp_sts_t sts;

  mscbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  mscbp_datapath #(
    .SYSEX_DEPTH (SYSEX_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  `MSCBP_ASSERT_IMP(a_held_blocks_rx, sts.in_full, !in_ch.ready)
  `MSCBP_ASSERT_IMP(a_decode_needs_byte, cmd.process, sts.in_full)
  `MSCBP_ASSERT_IMP(a_payload_slot_free, cmd.emit_pay, sts.out_free && !cmd.process)
  `MSCBP_ASSERT_NXT(a_event_sets_valid, cmd.process && sts.needs_out, out_ch.valid)

endmodule

`default_nettype wire
